FILE: rtl/drbe_pkg.sv
// ----------------------------------------------------------------------------
// drbe_pkg
// Shared widths, key constants and the modular add step of the block
// encryptor.
// ----------------------------------------------------------------------------
package drbe_pkg;

    localparam int BLOCK_BYTES = 50;
    localparam int NUM_BYTES   = BLOCK_BYTES + 1;
    localparam int W           = 8 * NUM_BYTES;
    localparam int CNT_W       = $clog2(W + 1);
    localparam int LEN_W       = $clog2(NUM_BYTES + 1);
    localparam int BCNT_W      = 6;

    localparam logic [7:0] TOP_MARK = 8'h15;

    localparam logic [W-1:0] MOD = 408'h35b5a394_2806d8a2_2695d771_b23cfd56_1c4a19b6_a3b02600_365a306e_3c4d6338_1bd41c13_6489364c_f2ba2a58_f4fee1fd_ac7e79;

    localparam logic [W-1:0] EXP = 408'h23ce6d0d_7004906c_19b93a4b_cc28a8e4_12dc1124_6d201955_7987ab5c_a818a3d3_c8e3276d_4270cb80_21d6bda4_296d47b1_e5e2a3;

    function automatic logic [W-1:0] f_addmod(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W:0]   s;
        logic [W+1:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = {1'b0, s} - {2'b00, MOD};
        return d[W+1] ? s[W-1:0] : d[W-1:0];
    endfunction

endpackage

FILE: rtl/drbe_mulmod.sv
// ----------------------------------------------------------------------------
// drbe_mulmod
// Interleaved modular multiplier, multiplier bits MSB first: a doubling step
// and, for a set bit, an add step, each reduced by one subtract of the modulus.
// ----------------------------------------------------------------------------
module drbe_mulmod (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [drbe_pkg::W-1:0] i_a,
    input  logic [drbe_pkg::W-1:0] i_b,
    output logic                  o_done,
    output logic [drbe_pkg::W-1:0] o_prod
);
    import drbe_pkg::*;

    logic             r_busy;
    logic             r_add;
    logic             r_done;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [CNT_W-1:0] r_cnt;

    logic [W-1:0] n_acc;

    assign n_acc  = f_addmod(r_acc, r_add ? r_b : r_acc);
    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_add  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_add  <= 1'b0;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_acc <= n_acc;
                if (!r_add && r_a[W-1]) begin
                    r_add <= 1'b1;
                end else begin
                    // advance to next multiplier bit
                    r_add <= 1'b0;
                    r_a   <= {r_a[W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/delta_rsa_block_encryptor.sv
// ----------------------------------------------------------------------------
// delta_rsa_block_encryptor
// Delta-codes 50 plain bytes into a block, raises it to the fixed private
// exponent modulo the fixed 408-bit modulus and streams the result out.
// ----------------------------------------------------------------------------
// Operation: one byte is taken per request inside a block; the request that
//   completes a block starts 592 modular products (408 squarings, 184
//   multiplies), each run one multiplier bit at a time with an extra add
//   step for each set bit, then a scan for leading zero bytes and 1..51
//   outputs.
// Input is held off from a block's last request until its last output byte is taken.
// Reset: synchronous active low; clears previous byte, count and sequencer.
module delta_rsa_block_encryptor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] plain_byte
    input  logic       s_axis_tuser,   // [0] restart
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] cipher_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] accum_zero
);
    import drbe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_SQW, S_MUL, S_MULW, S_SCAN, S_OUT
    } t_state;

    t_state              r_state;
    logic [7:0]          r_prev;
    logic [BCNT_W-1:0]   r_bcnt;
    logic [W-9-8:0]      r_blk;
    logic [W-1:0]        r_base;
    logic [W-1:0]        r_r;
    logic [W-1:0]        r_res;
    logic [W-1:0]        r_exp;
    logic [CNT_W-1:0]    r_ecnt;
    logic [LEN_W-1:0]    r_len;

    logic              in_acc;
    logic [7:0]        n_diff;
    logic [BCNT_W-1:0] n_bcnt;
    logic              mm_start;
    logic              mm_done;
    logic [W-1:0]      mm_prod;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign n_bcnt  = s_axis_tuser ? '0 : r_bcnt;
    assign n_diff  = s_axis_tdata - (s_axis_tuser ? 8'h00 : r_prev);
    assign mm_start = (r_state == S_SQ) || (r_state == S_MUL);

    drbe_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (r_r),
        .i_b     ((r_state == S_SQ) ? r_r : r_base),
        .o_done  (mm_done),
        .o_prod  (mm_prod)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_res[7:0];
    assign m_axis_tlast  = (r_len == LEN_W'(1));
    assign m_axis_tuser  = (r_prev == 8'h00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prev  <= 8'h00;
            r_bcnt  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_prev <= s_axis_tdata;
                        r_blk  <= {n_diff, r_blk[W-17:8]};
                        if (n_bcnt == BCNT_W'(BLOCK_BYTES - 1)) begin
                            r_bcnt  <= '0;
                            r_base  <= {TOP_MARK, n_diff, r_blk};
                            r_r     <= W'(1);
                            r_exp   <= EXP;
                            r_ecnt  <= CNT_W'(W);
                            r_state <= S_SQ;
                        end else begin
                            r_bcnt <= n_bcnt + 1'b1;
                        end
                    end
                end
                S_SQ:  r_state <= S_SQW;
                S_MUL: r_state <= S_MULW;
                S_SQW, S_MULW: begin
                    if (mm_done) begin
                        r_r <= mm_prod;
                        if (r_state == S_SQW && r_exp[W-1]) begin
                            r_state <= S_MUL;
                        end else begin
                            r_exp  <= {r_exp[W-2:0], 1'b0};
                            r_ecnt <= r_ecnt - 1'b1;
                            if (r_ecnt == CNT_W'(1)) begin
                                r_res   <= mm_prod;
                                r_len   <= LEN_W'(NUM_BYTES);
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_SQ;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    // drop leading zero bytes, keep at least one
                    if (r_r[W-1:W-8] == 8'h00 && r_len != LEN_W'(1)) begin
                        r_r   <= {r_r[W-9:0], 8'h00};
                        r_len <= r_len - 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_res <= {8'h00, r_res[W-1:8]};
                        r_len <= r_len - 1'b1;
                        if (r_len == LEN_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/drbe_checker.sv
// ----------------------------------------------------------------------------
// drbe_checker
// Port-level checks of the block encryptor, bound to the top level.
// ----------------------------------------------------------------------------
module drbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while output valid");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside ciphertext burst");

    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("input not reopened after last byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled request changed");

endmodule

bind delta_rsa_block_encryptor drbe_checker u_drbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
